FILE: src/seqle_pkg.sv
// Shared constants for the sequential list engine: field widths and command codes.
package seqle_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

endpackage

FILE: src/seqle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module seqle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/sequential_list_engine_top.sv
// Top level of the sequential list engine: command sequencer over one list RAM.
//
// Usage:
//   Input channel s_*: one command per transfer (get, locate, insert, delete,
//   clear) with a 1-based position and a 32-bit signed value. Output channel
//   m_*: exactly one result per command (ok, value_out, found_at, count,
//   is_empty), in command order.
//   The list lives in one RAM with one write and one registered read port.
//   A sequencer moves or compares one entry per cycle through that port pair.
//   Order of steps per command: get reads the entry at the position; insert
//   shifts entries from the list end down to the position, then writes the
//   value; delete reads the entry, then shifts the entries behind it up one
//   place; locate compares entries from the first on until a match or the end;
//   clear and rejected commands go straight to the result.
//   s_tready is high only while the sequencer is idle; one command at a time.
//   A finished result sits in the output register, so the next command is
//   taken while it waits. If the receiver stalls, the following result waits
//   in the sequencer until the output register frees up.
//   Reset (aresetn low, synchronous) empties the list and drops any result.
module sequential_list_engine_top import seqle_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // cmd[2:0], position[9:3], value_in[41:10], zero pad [47:42]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // ok[0], value_out[32:1], found_at[39:33], count[46:40], is_empty[47]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GET    = 3'd1;
    localparam logic [2:0] ST_LOC    = 3'd2;
    localparam logic [2:0] ST_INS    = 3'd3;
    localparam logic [2:0] ST_PUT    = 3'd4;
    localparam logic [2:0] ST_DFIRST = 3'd5;
    localparam logic [2:0] ST_DEL    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [LW-1:0]        len_reg, len_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [VAL_W-1:0]     val_reg, val_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic                 ok_reg, ok_next;
    logic [VAL_W-1:0]     vout_reg, vout_next;
    logic [CNT_W-1:0]     found_reg, found_next;

    logic [CMD_W-1:0]     in_cmd;
    logic [POS_W-1:0]     in_pos;
    logic [VAL_W-1:0]     in_val;
    logic [CW-1:0]        pos_c, len_c;
    logic                 get_ok, ins_ok;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [VAL_W-1:0]     mem_wdata, mem_rdata;

    assign in_cmd = s_tdata[2:0];
    assign in_pos = s_tdata[9:3];
    assign in_val = s_tdata[41:10];

    assign pos_c  = CW'(in_pos);
    assign len_c  = CW'(len_reg);
    assign get_ok = (pos_c != '0) && (pos_c <= len_c);
    assign ins_ok = (pos_c != '0) && (pos_c <= len_c + CW'(1)) && (len_c < CW'(DEPTH));

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    seqle_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_list_ram (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        vout_next     = vout_reg;
        found_next    = found_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = mem_rdata;
        mem_raddr     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                mem_raddr = AW'(pos_c - CW'(1));
                if (s_tvalid) begin
                    pos_next   = pos_c;
                    val_next   = in_val;
                    ok_next    = 1'b0;
                    vout_next  = '0;
                    found_next = '0;
                    unique case (in_cmd)
                        CMD_GET: begin
                            state_next = get_ok ? ST_GET : ST_DONE;
                        end
                        CMD_LOCATE: begin
                            mem_raddr = '0;
                            ok_next   = 1'b1;
                            idx_next  = '0;
                            state_next = (len_reg == '0) ? ST_DONE : ST_LOC;
                        end
                        CMD_INSERT: begin
                            mem_raddr = AW'(len_c - CW'(1));
                            idx_next  = AW'(len_c);
                            if (!ins_ok) begin
                                state_next = ST_DONE;
                            end else if (pos_c == len_c + CW'(1)) begin
                                state_next = ST_PUT;
                            end else begin
                                state_next = ST_INS;
                            end
                        end
                        CMD_DELETE: begin
                            state_next = get_ok ? ST_DFIRST : ST_DONE;
                        end
                        CMD_CLEAR: begin
                            len_next   = '0;
                            ok_next    = 1'b1;
                            state_next = ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_GET: begin
                vout_next  = mem_rdata;
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_LOC: begin
                mem_raddr = idx_reg + AW'(1);
                if (mem_rdata == val_reg) begin
                    found_next = CNT_W'(CW'(idx_reg) + CW'(1));
                    state_next = ST_DONE;
                end else if (CW'(idx_reg) + CW'(1) == len_c) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_INS: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                mem_raddr = idx_reg - AW'(2);
                if (CW'(idx_reg) == pos_reg) begin
                    state_next = ST_PUT;
                end else begin
                    idx_next = idx_reg - AW'(1);
                end
            end
            ST_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(pos_reg - CW'(1));
                mem_wdata  = val_reg;
                len_next   = len_reg + LW'(1);
                ok_next    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DFIRST: begin
                vout_next = mem_rdata;
                ok_next   = 1'b1;
                mem_raddr = AW'(pos_reg);
                idx_next  = AW'(pos_reg - CW'(1));
                if (pos_reg == len_c) begin
                    len_next   = len_reg - LW'(1);
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DEL;
                end
            end
            ST_DEL: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                mem_raddr = idx_reg + AW'(2);
                if (CW'(idx_reg) + CW'(2) == len_c) begin
                    len_next   = len_reg - LW'(1);
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(len_reg == '0), CNT_W'(len_reg), found_reg,
                                     vout_reg, ok_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        vout_reg    <= vout_next;
        found_reg   <= found_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a command is in progress");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(len_reg) <= CW'(DEPTH))
        else $error("list length beyond capacity");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("list RAM written while idle");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOC) |-> (CW'(idx_reg) < len_c))
        else $error("locate scan past list end");

    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == '0 && m_tdata[39:33] == '0))
        else $error("rejected command carries data");

endmodule
